[src/assert_macros.svh]
// assertion macros included by the alu rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/alucf_pkg.sv]
// types and constants of the alu with compare flags
package alucf_pkg;

    typedef enum logic [3:0] {
        CMD_ADD     = 4'd0,
        CMD_ROR     = 4'd1,
        CMD_SUB     = 4'd2,
        CMD_LDL     = 4'd3,
        CMD_AND     = 4'd4,
        CMD_OR      = 4'd5,
        CMD_XOR     = 4'd6,
        CMD_XNOR    = 4'd7,
        CMD_SHL     = 4'd8,
        CMD_LSHR    = 4'd9,
        CMD_ASHR    = 4'd10,
        CMD_BINS    = 4'd11,
        CMD_BEXTS   = 4'd12,
        CMD_BEXTU   = 4'd13,
        CMD_FLIP    = 4'd14,
        CMD_ILLEGAL = 4'd15
    } t_cmd;

    typedef enum logic [1:0] {
        DW_BYTE = 2'd0,
        DW_HALF = 2'd1,
        DW_WORD = 2'd2
    } t_dwidth;

    // flag bit positions
    localparam int unsigned FLAG_ZERO  = 0;
    localparam int unsigned FLAG_CARRY = 1;
    localparam int unsigned FLAG_OVF   = 2;
    localparam int unsigned FLAG_SIGN  = 3;
    localparam int unsigned FLAG_GE    = 4;
    localparam int unsigned FLAG_GT    = 5;
    localparam int unsigned FLAG_ABOVE = 6;

    // bit-flip swap masks
    localparam logic [31:0] FLIP_M1  = 32'h5555_5555;
    localparam logic [31:0] FLIP_M2  = 32'h3333_3333;
    localparam logic [31:0] FLIP_M4  = 32'h0F0F_0F0F;
    localparam logic [31:0] FLIP_M8  = 32'h00FF_00FF;
    localparam logic [31:0] FLIP_M16 = 32'h0000_FFFF;

    // field width code zero stands for sixteen bits
    localparam logic [4:0] FIELD_W_ZERO = 5'd16;

    typedef struct packed {
        t_cmd        command;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic        compare_mode;
        logic [1:0]  data_width;
    } t_in;

    typedef struct packed {
        logic [31:0] result;
        logic [6:0]  flags;
        logic        illegal;
    } t_out;

endpackage

[src/alu_with_compare_flags.sv]
// alu with compare flags: input register, one pass of logic, result register
// a word taken into the input register moves on to the result register once that register is free
// throughput: one word per cycle; the result register frees as it is taken,
// so the input side only stalls while both registers are full and output stalls
// reset: synchronous active-low clears both valid bits, payload is not reset
module alu_with_compare_flags (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  alucf_pkg::t_in    i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output alucf_pkg::t_out   o_out_data,
    input  logic              i_out_stall
);

    `include "assert_macros.svh"

    // pipeline registers
    logic            r_in_valid;
    alucf_pkg::t_in  r_in;
    logic            r_out_valid;
    alucf_pkg::t_out r_out;

    // handshake control
    logic            out_free;   // result register can load this cycle
    logic            in_load;    // input register takes a new word
    logic            move;       // word in input register goes to result register

    // operation datapath
    logic [31:0]     a;
    logic [31:0]     b;
    logic [4:0]      sh;         // shift amount and field position
    logic [4:0]      fwid;       // field width 1..16
    logic [16:0]     fmask;      // low mask of field width
    logic [31:0]     fmask32;
    logic [31:0]     ins_mask;
    logic [31:0]     ext;
    logic [63:0]     rot;
    logic [31:0]     fl1, fl2, fl4, fl8, fl16;
    logic [31:0]     res;
    logic            bad;

    // flag datapath
    logic [8:0]      add8;
    logic [16:0]     add16;
    logic [32:0]     add32;
    logic            sign, ahi, bhi, zero, carry_add, carry_sub, carry, ovf, ge;
    logic [6:0]      flags;
    alucf_pkg::t_out n_out;

    // ---------------------------------------------------------------
    // handshake: the result register loads whenever it is empty or being
    // taken; the input register refills when it is empty or moving on
    // ---------------------------------------------------------------
    assign out_free    = !r_out_valid || !i_out_stall;
    assign move        = r_in_valid && out_free;
    assign in_load     = !r_in_valid || out_free;
    assign o_in_stall  = !in_load;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    // ---------------------------------------------------------------
    // operation: shifts and rotate use the low five bits of b, bit
    // fields take position from b[4:0] and width from b[8:5]
    // ---------------------------------------------------------------
    assign a        = r_in.operand_a;
    assign b        = r_in.operand_b;
    assign sh       = b[4:0];
    assign fwid     = (b[8:5] == 4'd0) ? alucf_pkg::FIELD_W_ZERO : {1'b0, b[8:5]};
    assign fmask    = (17'd1 << fwid) - 17'd1;
    assign fmask32  = {15'd0, fmask};
    assign ins_mask = fmask32 << sh;
    assign ext      = (a >> sh) & fmask32;
    assign rot      = {a, a} >> sh;

    // staged flip: swap bits, pairs, nibbles, bytes, halves as b selects
    assign fl1  = b[0] ? (((a   & alucf_pkg::FLIP_M1)  << 1)
                        | ((a   >> 1)  & alucf_pkg::FLIP_M1))  : a;
    assign fl2  = b[1] ? (((fl1 & alucf_pkg::FLIP_M2)  << 2)
                        | ((fl1 >> 2)  & alucf_pkg::FLIP_M2))  : fl1;
    assign fl4  = b[2] ? (((fl2 & alucf_pkg::FLIP_M4)  << 4)
                        | ((fl2 >> 4)  & alucf_pkg::FLIP_M4))  : fl2;
    assign fl8  = b[3] ? (((fl4 & alucf_pkg::FLIP_M8)  << 8)
                        | ((fl4 >> 8)  & alucf_pkg::FLIP_M8))  : fl4;
    assign fl16 = b[4] ? (((fl8 & alucf_pkg::FLIP_M16) << 16)
                        | ((fl8 >> 16) & alucf_pkg::FLIP_M16)) : fl8;

    always_comb begin
        res = 32'd0;
        bad = 1'b0;
        unique case (r_in.command)
            alucf_pkg::CMD_ADD:   res = a + b;
            alucf_pkg::CMD_ROR:   res = rot[31:0];
            alucf_pkg::CMD_SUB:   res = a - b;
            alucf_pkg::CMD_LDL:   res = {a[21:0], b[9:0]};
            alucf_pkg::CMD_AND:   res = a & b;
            alucf_pkg::CMD_OR:    res = a | b;
            alucf_pkg::CMD_XOR:   res = a ^ b;
            alucf_pkg::CMD_XNOR:  res = ~(a ^ b);
            alucf_pkg::CMD_SHL:   res = a << sh;
            alucf_pkg::CMD_LSHR:  res = a >> sh;
            alucf_pkg::CMD_ASHR:  res = $unsigned($signed(a) >>> sh);
            alucf_pkg::CMD_BINS:  res = (a & ~ins_mask) | (((b >> 10) << sh) & ins_mask);
            alucf_pkg::CMD_BEXTS: res = ext[4'(fwid - 5'd1)] ? (ext | ~fmask32) : ext;
            alucf_pkg::CMD_BEXTU: res = ext;
            alucf_pkg::CMD_FLIP:  res = fl16;
            alucf_pkg::CMD_ILLEGAL: bad = 1'b1;
            default:              bad = 1'b1;
        endcase
    end

    // ---------------------------------------------------------------
    // flags at the selected width; unused width code counts as word
    // carry is the add carry-out or the subtract borrow, zero otherwise
    // ---------------------------------------------------------------
    assign add8  = {1'b0, a[7:0]}  + {1'b0, b[7:0]};
    assign add16 = {1'b0, a[15:0]} + {1'b0, b[15:0]};
    assign add32 = {1'b0, a}       + {1'b0, b};

    always_comb begin
        unique case (r_in.data_width)
            alucf_pkg::DW_BYTE: begin
                sign      = res[7];
                ahi       = a[7];
                bhi       = b[7];
                zero      = (res[7:0] == 8'd0);
                carry_add = add8[8];
                carry_sub = (a[7:0] < b[7:0]);
            end
            alucf_pkg::DW_HALF: begin
                sign      = res[15];
                ahi       = a[15];
                bhi       = b[15];
                zero      = (res[15:0] == 16'd0);
                carry_add = add16[16];
                carry_sub = (a[15:0] < b[15:0]);
            end
            default: begin
                sign      = res[31];
                ahi       = a[31];
                bhi       = b[31];
                zero      = (res == 32'd0);
                carry_add = add32[32];
                carry_sub = (a < b);
            end
        endcase
    end

    assign carry = (r_in.command == alucf_pkg::CMD_ADD) ? carry_add
                 : (r_in.command == alucf_pkg::CMD_SUB) ? carry_sub : 1'b0;
    assign ovf   = (sign != ahi) && (ahi != bhi);
    assign ge    = (sign == ovf);

    always_comb begin
        flags = 7'd0;
        if (r_in.compare_mode && !bad) begin
            flags[alucf_pkg::FLAG_ZERO]  = zero;
            flags[alucf_pkg::FLAG_CARRY] = carry;
            flags[alucf_pkg::FLAG_OVF]   = ovf;
            flags[alucf_pkg::FLAG_SIGN]  = sign;
            flags[alucf_pkg::FLAG_GE]    = ge;
            flags[alucf_pkg::FLAG_GT]    = ge && !zero;
            flags[alucf_pkg::FLAG_ABOVE] = !carry && !zero;
        end
    end

    assign n_out.result  = res;
    assign n_out.flags   = flags;
    assign n_out.illegal = bad;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `ASSERT_IMPLY(a_illegal_clean, i_clk, i_rst_n,
        r_out_valid && r_out.illegal,
        r_out.result == 32'd0 && r_out.flags == 7'd0, "illegal word with nonzero payload")
    `ASSERT_IMPLY(a_above_not_zero, i_clk, i_rst_n,
        r_out_valid && r_out.flags[alucf_pkg::FLAG_ABOVE],
        !r_out.flags[alucf_pkg::FLAG_ZERO], "above flag together with zero flag")
    `ASSERT_IMPLY(a_gt_needs_ge, i_clk, i_rst_n,
        r_out_valid && r_out.flags[alucf_pkg::FLAG_GT],
        r_out.flags[alucf_pkg::FLAG_GE], "greater flag without greater-or-equal")
    `ASSERT_IMPLY(a_stall_only_full, i_clk, i_rst_n,
        o_in_stall, r_in_valid && r_out_valid && i_out_stall,
        "input stalled while a register is free")
    `ASSERT_NEXT(a_move_lands, i_clk, i_rst_n,
        move, r_out_valid, "word lost between input and result register")

endmodule

[dv/tb_alu_with_compare_flags.sv]
// testbench of the alu with compare flags: queued words, random idling, predicted results
module tb_alu_with_compare_flags;
    timeunit 1ns;
    timeprecision 1ps;

    // data width code that the package leaves unnamed, handled as word
    localparam logic [1:0] DW_SPARE = 2'd3;

    localparam int unsigned RANDOM_WORDS = 1200;
    // last stretch of the run starts no new idling on either side
    localparam int unsigned TAIL_WORDS   = 100;
    // two register stages inside the block, plus margin
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    alucf_pkg::t_in    i_in_data   = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    alucf_pkg::t_out   o_out_data;
    logic              i_out_stall = 1'b0;

    // operations waiting to be offered, and results predicted for taken words
    alucf_pkg::t_in    alu_ops[$];
    alucf_pkg::t_out   predicted_results[$];

    int unsigned total_words = 0;
    int unsigned words_taken = 0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    // idle percentages, retuned now and then so busy and calm stretches alternate
    int unsigned in_gap_pct  = 20;
    int unsigned out_gap_pct = 20;
    int unsigned send_gap    = 0;
    int unsigned hold_left   = 0;
    logic        in_taken    = 1'b0;

    alu_with_compare_flags uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #5 i_clk = ~i_clk;

    // expected result, flags and illegal bit of one operation
    function automatic alucf_pkg::t_out compute_alu(alucf_pkg::t_in w);
        alucf_pkg::t_out o;
        logic [31:0] a, b, r, fmask, imask;
        logic [4:0]  amt;
        int unsigned wid, top;
        logic [63:0] span, ra, rb, wide;
        logic        zero, sign, ovf, carry, ge;
        o     = '0;
        r     = '0;
        a     = w.operand_a;
        b     = w.operand_b;
        amt   = b[4:0];
        // field width code zero stands for sixteen bits
        wid   = 32'((b[8:5] == 4'd0) ? alucf_pkg::FIELD_W_ZERO : {1'b0, b[8:5]});
        fmask = (32'h1 << wid) - 32'h1;
        case (w.command)
            alucf_pkg::CMD_ADD:   r = a + b;
            alucf_pkg::CMD_ROR:   r = (amt == 5'd0) ? a : ((a >> amt) | (a << (32 - amt)));
            alucf_pkg::CMD_SUB:   r = a - b;
            alucf_pkg::CMD_LDL:   r = {a[21:0], b[9:0]};
            alucf_pkg::CMD_AND:   r = a & b;
            alucf_pkg::CMD_OR:    r = a | b;
            alucf_pkg::CMD_XOR:   r = a ^ b;
            alucf_pkg::CMD_XNOR:  r = ~(a ^ b);
            alucf_pkg::CMD_SHL:   r = a << amt;
            alucf_pkg::CMD_LSHR:  r = a >> amt;
            alucf_pkg::CMD_ASHR:  r = $signed(a) >>> amt;
            alucf_pkg::CMD_BINS: begin
                imask = fmask << amt;
                r = (a & ~imask) | (((b >> 10) << amt) & imask);
            end
            alucf_pkg::CMD_BEXTS: begin
                r = (a >> amt) & fmask;
                if (r[wid - 1]) begin
                    r = r | ~fmask;
                end
            end
            alucf_pkg::CMD_BEXTU: r = (a >> amt) & fmask;
            alucf_pkg::CMD_FLIP: begin
                r = a;
                if (b[0]) r = ((r & alucf_pkg::FLIP_M1) << 1)
                            | ((r >> 1) & alucf_pkg::FLIP_M1);
                if (b[1]) r = ((r & alucf_pkg::FLIP_M2) << 2)
                            | ((r >> 2) & alucf_pkg::FLIP_M2);
                if (b[2]) r = ((r & alucf_pkg::FLIP_M4) << 4)
                            | ((r >> 4) & alucf_pkg::FLIP_M4);
                if (b[3]) r = ((r & alucf_pkg::FLIP_M8) << 8)
                            | ((r >> 8) & alucf_pkg::FLIP_M8);
                if (b[4]) r = ((r & alucf_pkg::FLIP_M16) << 16)
                            | ((r >> 16) & alucf_pkg::FLIP_M16);
            end
            default: o.illegal = 1'b1;
        endcase
        if (!o.illegal && w.compare_mode) begin
            top  = (w.data_width == alucf_pkg::DW_BYTE) ? 7
                 : (w.data_width == alucf_pkg::DW_HALF) ? 15 : 31;
            span = (64'h1 << (top + 1)) - 64'h1;
            ra   = {32'h0, a} & span;
            rb   = {32'h0, b} & span;
            zero = (({32'h0, r} & span) == 64'h0);
            sign = r[top];
            // subtract overflow rule, applied to every operation
            ovf  = (sign != a[top]) && (a[top] != b[top]);
            carry = 1'b0;
            if (w.command == alucf_pkg::CMD_ADD) begin
                wide  = ra + rb;
                carry = wide[top + 1];
            end else if (w.command == alucf_pkg::CMD_SUB) begin
                wide  = ra - rb;
                carry = wide[top + 1];
            end
            ge = (sign == ovf);
            o.flags[alucf_pkg::FLAG_ABOVE] = !carry && !zero;
            o.flags[alucf_pkg::FLAG_GT]    = ge && !zero;
            o.flags[alucf_pkg::FLAG_GE]    = ge;
            o.flags[alucf_pkg::FLAG_SIGN]  = sign;
            o.flags[alucf_pkg::FLAG_OVF]   = ovf;
            o.flags[alucf_pkg::FLAG_CARRY] = carry;
            o.flags[alucf_pkg::FLAG_ZERO]  = zero;
        end
        o.result = r;
        return o;
    endfunction

    // operand values biased toward the corners
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3:       return $urandom_range(0, 300);
            4:       return {24'h0, 8'($urandom)} | ($urandom_range(0, 1) ? 32'h80 : 32'h0);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(alucf_pkg::t_cmd cmd, logic [31:0] a, logic [31:0] b,
                            logic cmp, logic [1:0] dw);
        alucf_pkg::t_in w;
        w.command      = cmd;
        w.operand_a    = a;
        w.operand_b    = b;
        w.compare_mode = cmp;
        w.data_width   = dw;
        alu_ops.push_back(w);
    endtask

    task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        fail_count++;
    endtask

    // driver: offers the next word at the falling edge once the last one was taken
    always @(negedge i_clk) begin : drive
        logic tail;
        tail = alu_ops.size() < TAIL_WORDS;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                if (send_gap == 0 && !tail && $urandom_range(0, 99) < in_gap_pct) begin
                    send_gap = $urandom_range(1, 9);
                end
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (alu_ops.size() > 0) begin
                    i_in_data  <= alu_ops.pop_front();
                    i_in_valid <= 1'b1;
                    // change the idling mix every so often
                    if (alu_ops.size() % 128 == 0) begin
                        case ($urandom_range(0, 2))
                            0:       in_gap_pct = 0;
                            1:       in_gap_pct = 10;
                            default: in_gap_pct = 35;
                        endcase
                        case ($urandom_range(0, 2))
                            0:       out_gap_pct = 0;
                            1:       out_gap_pct = 10;
                            default: out_gap_pct = 35;
                        endcase
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            // receiver stalls in bursts, independent of what is on the output
            if (hold_left == 0 && !tail && $urandom_range(0, 99) < out_gap_pct) begin
                hold_left = $urandom_range(1, 9);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // monitor: records taken words and checks results at the rising edge
    always @(posedge i_clk) begin : watch
        alucf_pkg::t_out want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                predicted_results.push_back(compute_alu(i_in_data));
                words_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: result word with nothing expected, got %h", $time,
                             o_out_data);
                    fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    if (o_out_data.result !== want.result)
                        report_field("result", want.result, o_out_data.result);
                    if (o_out_data.flags !== want.flags)
                        report_field("flags", 32'(want.flags), 32'(o_out_data.flags));
                    if (o_out_data.illegal !== want.illegal)
                        report_field("illegal", 32'(want.illegal), 32'(o_out_data.illegal));
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        alucf_pkg::t_cmd cmd;
        logic [1:0] dw;
        // directed: carry and zero at word width
        queue_op(alucf_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, alucf_pkg::DW_WORD);
        // byte add with signed overflow into bit 7
        queue_op(alucf_pkg::CMD_ADD, 32'h0000_007F, 32'h0000_0001, 1'b1, alucf_pkg::DW_BYTE);
        // borrow at half width
        queue_op(alucf_pkg::CMD_SUB, 32'h0000_0000, 32'h0000_0001, 1'b1, alucf_pkg::DW_HALF);
        queue_op(alucf_pkg::CMD_SUB, 32'h8000_0000, 32'h0000_0001, 1'b1, alucf_pkg::DW_WORD);
        // unused data width code behaves as word
        queue_op(alucf_pkg::CMD_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, DW_SPARE);
        // rotate by zero, and a rotate amount with high bits set
        queue_op(alucf_pkg::CMD_ROR, 32'h8000_0001, 32'h0000_0000, 1'b1, alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_ROR, 32'h1234_5678, 32'hFFFF_FFE5, 1'b1, alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_LDL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, alucf_pkg::DW_BYTE);
        queue_op(alucf_pkg::CMD_AND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_OR,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_XOR, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, alucf_pkg::DW_HALF);
        queue_op(alucf_pkg::CMD_XNOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, alucf_pkg::DW_BYTE);
        // shift amounts use only the low five bits
        queue_op(alucf_pkg::CMD_SHL,  32'hFFFF_FFFF, 32'h0000_003F, 1'b1, alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_LSHR, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_ASHR, 32'h8000_0000, 32'h0000_001F, 1'b1, alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_ASHR, 32'h8000_0000, 32'h0000_0020, 1'b1, alucf_pkg::DW_WORD);
        // field width code zero means sixteen bits, at the top position
        queue_op(alucf_pkg::CMD_BINS, 32'h0000_0000, 32'hFFFF_FC1F, 1'b1, alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_BINS, 32'hFFFF_FFFF, 32'h0000_01E0, 1'b1, alucf_pkg::DW_HALF);
        queue_op(alucf_pkg::CMD_BEXTS, 32'h8000_0000, 32'h0000_0010, 1'b1, alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_BEXTU, 32'h8000_0000, 32'h0000_003F, 1'b1, alucf_pkg::DW_BYTE);
        queue_op(alucf_pkg::CMD_BEXTS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_FLIP, 32'h0000_0001, 32'h0000_001F, 1'b1, alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_FLIP, 32'h1234_5678, 32'h0000_0001, 1'b1, alucf_pkg::DW_BYTE);
        // illegal opcode clears flags whatever the compare bit is
        queue_op(alucf_pkg::CMD_ILLEGAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                 alucf_pkg::DW_WORD);
        queue_op(alucf_pkg::CMD_ILLEGAL, 32'h0000_0000, 32'h0000_0000, 1'b0,
                 alucf_pkg::DW_BYTE);

        repeat (RANDOM_WORDS) begin
            cmd = alucf_pkg::t_cmd'(4'($urandom_range(0, 15)));
            dw  = ($urandom_range(0, 9) == 0) ? DW_SPARE : 2'($urandom_range(0, 2));
            queue_op(cmd, pick_operand(), pick_operand(), 1'($urandom_range(0, 3) != 0), dw);
        end
        total_words = alu_ops.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (words_taken == total_words && predicted_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && predicted_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
